### sv/bfgl_pkg.sv
// ----------------------------------------------------------------------------
// bfgl_pkg
// Types, constants and helpers shared by the glyph layout unit.
// ----------------------------------------------------------------------------
package bfgl_pkg;

  localparam int ATLAS_COLUMNS = 16;
  localparam logic [22:0] EXTENT_MAX = 23'h7FFFFF;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [11:0] SCALE_ONE = 12'd256;
  localparam logic [7:0] CELL_SIZE_RESET = 8'd8;
  localparam int ENTRY_WIDTH = 20;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_START = 2'd1,
    KIND_CHAR  = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

  typedef enum logic {
    RES_BLIT = 1'b0,
    RES_BOX  = 1'b1
  } res_kind_t;

  typedef enum logic [1:0] {
    REG_CELL_WIDTH        = 2'd0,
    REG_CELL_HEIGHT       = 2'd1,
    REG_FIRST_ROW         = 2'd2,
    REG_PROPORTIONAL_MODE = 2'd3
  } reg_index_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         char_code;
    logic [7:0]         glyph_width;
    logic signed [23:0] origin_x;
    logic signed [23:0] origin_y;
    logic [11:0]        scale;
  } item_t;

  typedef struct packed {
    res_kind_t          result_kind;
    logic signed [23:0] dest_x;
    logic signed [23:0] dest_y;
    logic [19:0]        dest_w;
    logic [19:0]        dest_h;
    logic [11:0]        src_x;
    logic signed [12:0] src_y;
    logic [7:0]         src_w;
    logic [7:0]         src_h;
    logic [22:0]        extent_w;
    logic [22:0]        extent_h;
  } result_t;

  // width table write request: code is below the glyph count when en is set
  typedef struct packed {
    logic        en;
    logic [7:0]  code;
    logic [7:0]  width;
    logic [11:0] offset;
  } tbl_wr_t;

  function automatic logic [22:0] sat_add(input logic [22:0] a, input logic [19:0] b);
    logic [23:0] sum;
    sum = {1'b0, a} + {4'd0, b};
    return sum[23] ? EXTENT_MAX : sum[22:0];
  endfunction

endpackage

### sv/bfgl_ram.sv
// ----------------------------------------------------------------------------
// bfgl_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bfgl_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/bfgl_engine.sv
// ----------------------------------------------------------------------------
// bfgl_engine
// Layout state, configuration registers and the combinational compute for the
// item held in the stage register.
// ----------------------------------------------------------------------------
module bfgl_engine #(
  parameter int GLYPH_COUNT = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  bfgl_pkg::reg_index_t  cfg_index,
  input  logic [7:0]            cfg_data,
  input  bfgl_pkg::item_t       item,
  input  logic                  go,
  input  logic [7:0]            entry_width,
  input  logic [11:0]           entry_offset,
  output bfgl_pkg::tbl_wr_t     wr,
  output logic                  res_valid,
  output bfgl_pkg::result_t     res
);

  import bfgl_pkg::*;

  logic [7:0]  cell_width;
  logic [7:0]  cell_height;
  logic [3:0]  first_row;
  logic        proportional_mode;

  logic [8:0]  load_index, load_index_next;
  logic [11:0] load_offset_acc, load_offset_acc_next;
  logic [23:0] pen_x, pen_x_next;
  logic [23:0] pen_y, pen_y_next;
  logic [23:0] line_start_x, line_start_x_next;
  logic [11:0] active_scale, active_scale_next;
  logic [22:0] widest_line, widest_line_next;
  logic [22:0] text_height, text_height_next;
  logic [22:0] line_width, line_width_next;

  logic [19:0]        line_adv;
  logic [9:0]         load_code;
  logic               load_full;
  logic               char_ignored;
  logic [7:0]         sw;
  logic [11:0]        sx;
  logic [19:0]        dw;
  logic signed [4:0]  row_diff;
  logic signed [13:0] sy_full;
  logic [22:0]        box_w;

  assign line_adv  = {12'd0, cell_height} * {8'd0, active_scale};
  assign load_code = {2'b00, first_row, 4'd0} + {1'b0, load_index};
  assign load_full = load_code >= 10'(GLYPH_COUNT);
  assign char_ignored = item.char_code[7] || ({1'b0, item.char_code} >= 9'(GLYPH_COUNT));

  assign sw = proportional_mode ? entry_width : cell_width;
  assign sx = proportional_mode ? entry_offset
                                : {4'd0, cell_width} * {8'd0, item.char_code[3:0]};
  assign dw = {12'd0, sw} * {8'd0, active_scale};
  assign row_diff = $signed({2'b00, item.char_code[6:4]}) - $signed({1'b0, first_row});
  assign sy_full  = $signed({6'd0, cell_height}) * $signed({{9{row_diff[4]}}, row_diff});
  assign box_w = (widest_line > line_width) ? widest_line : line_width;

  always_comb begin
    load_index_next      = load_index;
    load_offset_acc_next = load_offset_acc;
    pen_x_next           = pen_x;
    pen_y_next           = pen_y;
    line_start_x_next    = line_start_x;
    active_scale_next    = active_scale;
    widest_line_next     = widest_line;
    text_height_next     = text_height;
    line_width_next      = line_width;
    wr                   = '0;
    res_valid            = 1'b0;
    res                  = '0;

    case (item.kind)
      KIND_LOAD: begin
        if (item.glyph_width != 8'd0 && !load_full) begin
          wr.en     = 1'b1;
          wr.code   = load_code[7:0];
          wr.width  = item.glyph_width;
          wr.offset = load_offset_acc;
          load_index_next = load_index + 9'd1;
          // restart the offset at each new atlas row
          if (load_code[3:0] == 4'hF) begin
            load_offset_acc_next = '0;
          end else begin
            load_offset_acc_next = load_offset_acc + {4'd0, item.glyph_width};
          end
        end
      end
      KIND_START: begin
        pen_x_next        = item.origin_x;
        pen_y_next        = item.origin_y;
        line_start_x_next = item.origin_x;
        active_scale_next = item.scale;
        widest_line_next  = '0;
        text_height_next  = '0;
        line_width_next   = '0;
      end
      KIND_CHAR: begin
        if (!char_ignored) begin
          if (item.char_code == CHAR_NEWLINE) begin
            if (line_width > widest_line) begin
              widest_line_next = line_width;
            end
            line_width_next  = '0;
            text_height_next = sat_add(text_height, line_adv);
            pen_x_next       = line_start_x;
            pen_y_next       = pen_y + {4'd0, line_adv};
          end else begin
            line_width_next = sat_add(line_width, dw);
            pen_x_next      = pen_x + {4'd0, dw};
            if (item.char_code != CHAR_SPACE) begin
              res_valid       = 1'b1;
              res.result_kind = RES_BLIT;
              res.dest_x      = pen_x;
              res.dest_y      = pen_y;
              res.dest_w      = dw;
              res.dest_h      = line_adv;
              res.src_x       = sx;
              res.src_y       = sy_full[12:0];
              res.src_w       = sw;
              res.src_h       = cell_height;
            end
          end
        end
      end
      KIND_END: begin
        res_valid       = 1'b1;
        res.result_kind = RES_BOX;
        res.extent_w    = box_w;
        if (box_w != '0 || text_height != '0) begin
          res.extent_h = sat_add(text_height, line_adv);
        end else begin
          res.extent_h = text_height;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_width        <= CELL_SIZE_RESET;
      cell_height       <= CELL_SIZE_RESET;
      first_row         <= '0;
      proportional_mode <= 1'b0;
      load_index        <= '0;
      load_offset_acc   <= '0;
      pen_x             <= '0;
      pen_y             <= '0;
      line_start_x      <= '0;
      active_scale      <= SCALE_ONE;
      widest_line       <= '0;
      text_height       <= '0;
      line_width        <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_CELL_WIDTH:        cell_width        <= cfg_data;
          REG_CELL_HEIGHT:       cell_height       <= cfg_data;
          REG_FIRST_ROW:         first_row         <= cfg_data[3:0];
          REG_PROPORTIONAL_MODE: proportional_mode <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (go) begin
        load_index      <= load_index_next;
        load_offset_acc <= load_offset_acc_next;
        pen_x           <= pen_x_next;
        pen_y           <= pen_y_next;
        line_start_x    <= line_start_x_next;
        active_scale    <= active_scale_next;
        widest_line     <= widest_line_next;
        text_height     <= text_height_next;
        line_width      <= line_width_next;
      end
    end
  end

endmodule

### sv/bitmap_font_glyph_layout_unit.sv
// ----------------------------------------------------------------------------
// bitmap_font_glyph_layout_unit
// Turns a stream of load, start, character and end requests into glyph blit
// commands and text bounding boxes for a 16-column bitmap font atlas.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one request per beat, the request kind in s_tuser.
//   m_* carries blit commands (m_tuser 0) and bounding boxes (m_tuser 1).
//   Load, start, newline, space and high-byte requests give no result.
//   cfg_write/cfg_index/cfg_data write the four layout registers; write them
//   only while no request is in flight.
// Timing:
//   A result appears on m_tvalid once its request has passed the stage
//   register, where the registered width table read lands, and then the
//   output register; a stall on m_tready can hold it in either. One request
//   per cycle is taken while m_tready does not stall the output; the pen
//   update of the stage register is the loop that sets this.
// Reset:
//   rst clears the pen, box measures and load counters, sets the scale to
//   1.0 and the cell sizes to 8, and clears the width table valid bits, so
//   the block takes requests as soon as reset is released.
// Stall:
//   When m_tready is low a result holds in the output register; a request can
//   still enter an empty stage register, then s_tready drops.
// ----------------------------------------------------------------------------
module bitmap_font_glyph_layout_unit #(
  parameter int GLYPH_COUNT = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  // request stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // char_code[7:0], glyph_width[15:8], origin_x[39:16], origin_y[63:40],
  // scale[75:64], zero[79:76]
  input  logic [79:0]          s_tdata,
  // kind[1:0]
  input  logic [1:0]           s_tuser,
  // result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // dest_x[23:0], dest_y[47:24], dest_w[67:48], dest_h[87:68], src_x[99:88],
  // src_y[112:100], src_w[120:113], src_h[128:121], extent_w[151:129],
  // extent_h[174:152], zero[175]
  output logic [175:0]         m_tdata,
  // result_kind[0]
  output logic                 m_tuser
);

  import bfgl_pkg::*;

  localparam int AW = $clog2(GLYPH_COUNT);

  item_t               in_item;
  item_t               stage;
  logic                stage_valid;
  logic                go;
  logic                in_take;

  tbl_wr_t             wr;
  logic                tbl_we;
  logic [GLYPH_COUNT-1:0] tbl_valid;
  logic [ENTRY_WIDTH-1:0] ram_q;
  logic                fwd_hit;
  logic [ENTRY_WIDTH-1:0] fwd_data;
  logic [ENTRY_WIDTH-1:0] entry;

  logic                res_valid;
  result_t             res;
  result_t             out_res;
  logic                out_valid;

  assign in_item.kind        = kind_t'(s_tuser);
  assign in_item.char_code   = s_tdata[7:0];
  assign in_item.glyph_width = s_tdata[15:8];
  assign in_item.origin_x    = s_tdata[39:16];
  assign in_item.origin_y    = s_tdata[63:40];
  assign in_item.scale       = s_tdata[75:64];

  assign go       = stage_valid && (!out_valid || m_tready);
  assign s_tready = !stage_valid || go;
  assign in_take  = s_tvalid && s_tready;
  assign tbl_we   = go && wr.en;

  bfgl_ram #(
    .WIDTH (ENTRY_WIDTH),
    .DEPTH (GLYPH_COUNT)
  ) u_width_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (wr.code[AW-1:0]),
    .wdata ({wr.width, wr.offset}),
    .re    (in_take),
    .raddr (in_item.char_code[AW-1:0]),
    .rdata (ram_q)
  );

  // a write on the same edge as the read is not seen by the RAM: bypass it
  always_comb begin
    if (fwd_hit) begin
      entry = fwd_data;
    end else if (tbl_valid[stage.char_code[AW-1:0]]) begin
      entry = ram_q;
    end else begin
      entry = '0;
    end
  end

  bfgl_engine #(
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (reg_index_t'(cfg_index)),
    .cfg_data     (cfg_data),
    .item         (stage),
    .go           (go),
    .entry_width  (entry[19:12]),
    .entry_offset (entry[11:0]),
    .wr           (wr),
    .res_valid    (res_valid),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
      tbl_valid   <= '0;
      fwd_hit     <= 1'b0;
    end else begin
      if (s_tready) begin
        stage_valid <= s_tvalid;
      end
      if (in_take) begin
        fwd_hit <= tbl_we && (wr.code[AW-1:0] == in_item.char_code[AW-1:0]);
      end
      if (tbl_we) begin
        tbl_valid[wr.code[AW-1:0]] <= 1'b1;
      end
      if (go) begin
        out_valid <= res_valid;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stage    <= in_item;
      fwd_data <= {wr.width, wr.offset};
    end
    if (go && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.result_kind;
  assign m_tdata  = {1'b0, out_res.extent_h, out_res.extent_w, out_res.src_h, out_res.src_w,
                     out_res.src_y, out_res.src_x, out_res.dest_h, out_res.dest_w,
                     out_res.dest_y, out_res.dest_x};

endmodule

### tb/sv/tb_bfgl_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// tb_bfgl_scoreboard_pkg
// Layout predictor and command scoreboard for the glyph layout unit tests.
// It keeps its own width and offset tables, pen and box measures, works out
// the blit command or bounding box due for each taken request, and compares
// the commands that come out of the block against them in order.
// ----------------------------------------------------------------------------
package tb_bfgl_scoreboard_pkg;

  import bfgl_pkg::*;

  localparam int GLYPHS = 256;

  class glyph_layout_scoreboard;

    // layout registers
    logic [7:0]  cell_w;
    logic [7:0]  cell_h;
    logic [3:0]  first_row;
    logic        prop_mode;

    // glyph store
    logic [7:0]  width_tbl [GLYPHS];
    logic [11:0] offset_tbl [GLYPHS];
    int          load_idx;
    logic [11:0] load_acc;

    // pen and box measures
    logic [23:0] pen_x;
    logic [23:0] pen_y;
    logic [23:0] line_start_x;
    logic [11:0] scale;
    logic [22:0] widest;
    logic [22:0] text_h;
    logic [22:0] line_w;

    result_t     expected_commands [$];
    int          mismatches;

    function new();
      for (int i = 0; i < GLYPHS; i++) begin
        width_tbl[i] = '0;
        offset_tbl[i] = '0;
      end
      cell_w = CELL_SIZE_RESET;
      cell_h = CELL_SIZE_RESET;
      first_row = '0;
      prop_mode = 1'b0;
      load_idx = 0;
      load_acc = '0;
      pen_x = '0;
      pen_y = '0;
      line_start_x = '0;
      scale = SCALE_ONE;
      widest = '0;
      text_h = '0;
      line_w = '0;
      mismatches = 0;
    endfunction

    function void write_reg(reg_index_t idx, logic [7:0] value);
      case (idx)
        REG_CELL_WIDTH:        cell_w = value;
        REG_CELL_HEIGHT:       cell_h = value;
        REG_FIRST_ROW:         first_row = value[3:0];
        REG_PROPORTIONAL_MODE: prop_mode = value[0];
        default: begin
        end
      endcase
    endfunction

    // clamp at the largest unsigned Q15.8 extent
    function logic [22:0] add_clamped(logic [22:0] a, logic [19:0] b);
      logic [23:0] total;
      total = {1'b0, a} + 24'(b);
      return total[23] ? EXTENT_MAX : total[22:0];
    endfunction

    function int pending();
      return expected_commands.size();
    endfunction

    // advance the layout by one taken request, queue the command it gives
    function void apply_request(item_t req);
      result_t     cmd;
      int          code;
      logic [19:0] adv;
      logic [19:0] dw;
      logic [7:0]  sw;
      logic [11:0] sx;
      logic [22:0] ew;
      logic [22:0] eh;
      cmd = '0;
      adv = 20'(cell_h) * 20'(scale);
      case (req.kind)
        KIND_LOAD: begin
          code = int'(first_row) * ATLAS_COLUMNS + load_idx;
          if (req.glyph_width != 8'd0 && code < GLYPHS) begin
            width_tbl[code] = req.glyph_width;
            offset_tbl[code] = load_acc;
            load_idx++;
            // x offset restarts with each atlas row
            if ((code + 1) % ATLAS_COLUMNS == 0)
              load_acc = '0;
            else
              load_acc = load_acc + 12'(req.glyph_width);
          end
        end
        KIND_START: begin
          pen_x = req.origin_x;
          pen_y = req.origin_y;
          line_start_x = req.origin_x;
          scale = req.scale;
          widest = '0;
          text_h = '0;
          line_w = '0;
        end
        KIND_END: begin
          ew = (widest > line_w) ? widest : line_w;
          eh = text_h;
          // an empty text has no height at all
          if (ew != '0 || eh != '0)
            eh = add_clamped(eh, adv);
          cmd.result_kind = RES_BOX;
          cmd.extent_w = ew;
          cmd.extent_h = eh;
          expected_commands.push_back(cmd);
        end
        KIND_CHAR: begin
          if (req.char_code == CHAR_NEWLINE) begin
            if (line_w > widest)
              widest = line_w;
            line_w = '0;
            text_h = add_clamped(text_h, adv);
            pen_x = line_start_x;
            pen_y = pen_y + 24'(adv);
          end else if (!req.char_code[7]) begin
            if (prop_mode) begin
              sw = width_tbl[req.char_code];
              sx = offset_tbl[req.char_code];
            end else begin
              sw = cell_w;
              sx = 12'(16'(cell_w) * req.char_code[3:0]);
            end
            dw = 20'(sw) * 20'(scale);
            line_w = add_clamped(line_w, dw);
            if (req.char_code != CHAR_SPACE) begin
              cmd.result_kind = RES_BLIT;
              cmd.dest_x = pen_x;
              cmd.dest_y = pen_y;
              cmd.dest_w = dw;
              cmd.dest_h = adv;
              cmd.src_x = sx;
              cmd.src_y = 13'(int'(cell_h) * (int'(req.char_code[6:4]) - int'(first_row)));
              cmd.src_w = sw;
              cmd.src_h = cell_h;
              expected_commands.push_back(cmd);
            end
            pen_x = pen_x + 24'(dw);
          end
        end
        default: begin
        end
      endcase
    endfunction

    task report(string what);
      $display("ERROR glyph layout: %s", what);
      mismatches++;
    endtask

    task check_field(string field, logic [23:0] got, logic [23:0] want);
      if (got !== want)
        report($sformatf("%s got %h want %h", field, got, want));
    endtask

    task check_command(result_t got);
      result_t want;
      if (expected_commands.size() == 0) begin
        report($sformatf("command kind %0d with nothing outstanding", got.result_kind));
        return;
      end
      want = expected_commands.pop_front();
      check_field("result_kind", 24'(got.result_kind), 24'(want.result_kind));
      check_field("dest_x", got.dest_x, want.dest_x);
      check_field("dest_y", got.dest_y, want.dest_y);
      check_field("dest_w", 24'(got.dest_w), 24'(want.dest_w));
      check_field("dest_h", 24'(got.dest_h), 24'(want.dest_h));
      check_field("src_x", 24'(got.src_x), 24'(want.src_x));
      check_field("src_y", 24'(got.src_y), 24'(want.src_y));
      check_field("src_w", 24'(got.src_w), 24'(want.src_w));
      check_field("src_h", 24'(got.src_h), 24'(want.src_h));
      check_field("extent_w", 24'(got.extent_w), 24'(want.extent_w));
      check_field("extent_h", 24'(got.extent_h), 24'(want.extent_h));
    endtask

  endclass

endpackage

### tb/sv/tb_bitmap_font_glyph_layout_unit.sv
// ----------------------------------------------------------------------------
// tb_bitmap_font_glyph_layout_unit
// Drives load, start, character and end requests into the glyph layout unit
// under changing layout registers and random stalls on both streams, and
// checks every blit command and bounding box against the layout predictor.
// ----------------------------------------------------------------------------
module tb_bitmap_font_glyph_layout_unit;

  timeunit 1ns;
  timeprecision 1ps;

  import bfgl_pkg::*;
  import tb_bfgl_scoreboard_pkg::*;

  logic         clk;
  logic         rst = 1'b1;
  logic         cfg_write = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [7:0]   cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [79:0]  s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [175:0] m_tdata;
  logic         m_tuser;

  int tx_idle_pct = 10;
  int rx_idle_pct = 79;
  int requests_sent = 0;

  glyph_layout_scoreboard sb;

  bitmap_font_glyph_layout_unit dut (
    .clk, .rst,
    .cfg_write, .cfg_index, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // both streams are sampled at the same edge the handshake happens
  always @(posedge clk) begin : watch_streams
    result_t got;
    item_t   req;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.result_kind = res_kind_t'(m_tuser);
        got.dest_x = m_tdata[23:0];
        got.dest_y = m_tdata[47:24];
        got.dest_w = m_tdata[67:48];
        got.dest_h = m_tdata[87:68];
        got.src_x = m_tdata[99:88];
        got.src_y = m_tdata[112:100];
        got.src_w = m_tdata[120:113];
        got.src_h = m_tdata[128:121];
        got.extent_w = m_tdata[151:129];
        got.extent_h = m_tdata[174:152];
        sb.check_command(got);
      end
      if (s_tvalid && s_tready) begin
        req.kind = kind_t'(s_tuser);
        req.char_code = s_tdata[7:0];
        req.glyph_width = s_tdata[15:8];
        req.origin_x = s_tdata[39:16];
        req.origin_y = s_tdata[63:40];
        req.scale = s_tdata[75:64];
        sb.apply_request(req);
      end
    end
  end

  function automatic item_t random_item();
    item_t it;
    it.kind = kind_t'($urandom_range(3));
    it.char_code = 8'($urandom_range(255));
    it.glyph_width = 8'($urandom_range(255));
    it.origin_x = 24'($urandom);
    it.origin_y = 24'($urandom);
    it.scale = 12'($urandom_range(4095));
    return it;
  endfunction

  function automatic logic [7:0] pick_cell_size();
    case ($urandom_range(9))
      0: return 8'd1;
      1: return 8'd255;
      2: return 8'd0;
      default: return 8'($urandom_range(255, 1));
    endcase
  endfunction

  function automatic logic [3:0] pick_first_row();
    case ($urandom_range(5))
      0: return 4'd0;
      1: return 4'd15;
      default: return 4'($urandom_range(15));
    endcase
  endfunction

  function automatic logic [11:0] pick_scale();
    case ($urandom_range(9))
      0: return 12'd0;
      1: return 12'd4095;
      2, 3: return 12'($urandom_range(4095));
      default: return 12'($urandom_range(512, 64));
    endcase
  endfunction

  task automatic send_item(input item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= it.kind;
    s_tdata <= {4'd0, it.scale, it.origin_y, it.origin_x, it.glyph_width, it.char_code};
    do @(posedge clk); while (!s_tready);
    // high bytes and zero widths are dropped by the block
    if (!(it.kind == KIND_CHAR && it.char_code[7]) &&
        !(it.kind == KIND_LOAD && it.glyph_width == 8'd0))
      requests_sent++;
  endtask

  task automatic send_load(input logic [7:0] w);
    item_t it;
    it = random_item();
    it.kind = KIND_LOAD;
    it.glyph_width = w;
    send_item(it);
  endtask

  task automatic send_start(input logic [23:0] x, input logic [23:0] y,
                            input logic [11:0] s);
    item_t it;
    it = random_item();
    it.kind = KIND_START;
    it.origin_x = x;
    it.origin_y = y;
    it.scale = s;
    send_item(it);
  endtask

  task automatic send_char(input logic [7:0] code);
    item_t it;
    it = random_item();
    it.kind = KIND_CHAR;
    it.char_code = code;
    send_item(it);
  endtask

  task automatic send_end();
    item_t it;
    it = random_item();
    it.kind = KIND_END;
    send_item(it);
  endtask

  // hold off until every command is out, then let the pipeline empty
  task automatic drain(input int settle);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [7:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic write_regs(input logic [7:0] cw, input logic [7:0] ch,
                            input logic [3:0] row, input logic prop);
    write_reg(REG_CELL_WIDTH, cw);
    write_reg(REG_CELL_HEIGHT, ch);
    write_reg(REG_FIRST_ROW, {4'd0, row});
    write_reg(REG_PROPORTIONAL_MODE, {7'd0, prop});
    cfg_write <= 1'b0;
  endtask

  initial begin
    int target;
    int n;
    int pick;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset registers, fixed-width cells
    send_end();
    send_char(8'd65);
    send_start(24'h7FFFFF, 24'h800000, 12'd4095);
    send_char(8'd0);
    send_char(8'd127);
    send_char(CHAR_SPACE);
    send_char(CHAR_NEWLINE);
    send_char(8'd128);
    send_char(8'd255);
    send_end();
    send_load(8'd255);
    send_load(8'd0);
    send_load(8'd1);
    send_load(8'd128);
    drain(6);

    // largest cells, top row offset, table widths; newlines push the box height to saturation
    write_regs(8'd255, 8'd255, 4'd15, 1'b1);
    send_start(24'hFFFFFF, 24'h7FFFFF, 12'd4095);
    send_char(8'd1);
    send_char(8'd2);
    repeat (8) send_char(CHAR_NEWLINE);
    send_end();
    drain(6);

    for (int phase = 0; phase < 9; phase++) begin
      tx_idle_pct = (phase < 3) ? 10 : (phase < 6) ? 79 : 0;
      rx_idle_pct = (phase < 3) ? 79 : (phase < 6) ? 10 : 0;
      write_regs(pick_cell_size(), pick_cell_size(), pick_first_row(), phase[0]);
      target = requests_sent + 48;
      while (requests_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 15) begin
          n = $urandom_range(20, 1);
          repeat (n) send_load(($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(255)));
        end else if (pick < 25) begin
          n = $urandom_range(4, 1);
          repeat (n) send_item(random_item());
        end else begin
          send_start(24'($urandom), 24'($urandom), pick_scale());
          n = $urandom_range(24);
          repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 10)
              send_char(CHAR_NEWLINE);
            else if (pick < 22)
              send_char(CHAR_SPACE);
            else if (pick < 30)
              send_char(8'($urandom_range(255, 128)));
            else
              send_char(8'($urandom_range(127)));
          end
          // drop the end now and then
          if ($urandom_range(9) != 0)
            send_end();
        end
      end
      drain(6);
    end

    if (sb.mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

### filelist.f
sv/bfgl_pkg.sv
sv/bfgl_ram.sv
sv/bfgl_engine.sv
sv/bitmap_font_glyph_layout_unit.sv
tb/sv/tb_bfgl_scoreboard_pkg.sv
tb/sv/tb_bitmap_font_glyph_layout_unit.sv
